[hdl/tcce_pkg.sv]
// Package: shared widths, character codes, operation codes and sequencer states.
`default_nettype none

package tcce_pkg;

    // Default geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;
    localparam int CELLS_DEF   = COLUMNS_DEF * ROWS_DEF;

    // Field widths
    localparam int OP_W       = 2;
    localparam int CHAR_W     = 8;
    localparam int IDX_W      = 11;
    localparam int COL_OUT_W  = 7;
    localparam int LINE_OUT_W = 5;
    localparam int LOC_W      = 11;
    localparam int CELL_W     = 16;
    localparam int ATTR_W     = 8;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam int TAB_STOP   = 8;
    localparam int TAB_MASK   = ~(7);
    localparam int PROMPT_COL = 2;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_POS,
        S_PUT,
        S_SCROLL,
        S_FILL,
        S_READ,
        S_RDATA,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

[hdl/tcce_intf.sv]
// Interfaces: request and result channels with valid/ready handshake.
`default_nettype none

interface tcce_in_if;
    logic                              valid;
    logic                              ready;
    logic [tcce_pkg::OP_W-1:0]         operation;
    logic [tcce_pkg::CHAR_W-1:0]       char_code;
    logic [tcce_pkg::IDX_W-1:0]        cell_index;

    modport source (output valid, output operation, output char_code, output cell_index,
                    input ready);
    modport sink   (input valid, input operation, input char_code, input cell_index,
                    output ready);
endinterface

interface tcce_out_if;
    logic                              valid;
    logic                              ready;
    logic [tcce_pkg::COL_OUT_W-1:0]    cursor_col;
    logic [tcce_pkg::LINE_OUT_W-1:0]   cursor_line;
    logic [tcce_pkg::LOC_W-1:0]        cursor_addr;
    logic [tcce_pkg::CELL_W-1:0]       cell_value;
    logic                              scrolled;

    modport source (output valid, output cursor_col, output cursor_line,
                    output cursor_addr, output cell_value, output scrolled,
                    input ready);
    modport sink   (input valid, input cursor_col, input cursor_line,
                    input cursor_addr, input cell_value, input scrolled,
                    output ready);
endinterface

`default_nettype wire

[hdl/text_console_char_engine.sv]
// Top level: text console engine with cell store, cursor and scroll/clear sequencer.
//
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    operation, char_code, cell_index
//  out_ch    out  valid/ready    cursor_col, cursor_line, cursor_addr, cell_value, scrolled
//  cfg       in   cfg_write_en   cfg_write_data (text attribute)
//
// Sequence: a put passes S_POS, S_PUT and S_DONE, a read S_READ, S_RDATA and S_DONE, before the result beat.
// An unused operation code goes from accept straight to S_DONE.
// A put that scrolls first shifts the screen up, one shifted cell per cycle through the single
// RAM write port, then writes one blanked cell per cycle for the new row.
// A clear writes one blanked cell per cycle over the whole store.
// After reset the store is swept to blanks with the reset attribute; no beat is
// accepted meanwhile, configuration writes are. A stalled result holds in the output
// register; the engine finishes its current item and waits there before taking the next.
`default_nettype none

module text_console_char_engine #(
    parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    tcce_in_if.sink                          in_ch,
    tcce_out_if.source                       out_ch,
    input  wire logic                        cfg_write_en,
    input  wire logic [tcce_pkg::ATTR_W-1:0] cfg_write_data
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CIW   = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS + tcce_pkg::TAB_STOP);
    localparam int IXW   = (AW > tcce_pkg::IDX_W) ? AW : tcce_pkg::IDX_W;

    localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
    localparam logic [AW-1:0] SCROLL_END = AW'(CELLS - COLUMNS);
    localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);

    localparam logic [tcce_pkg::CELL_W-1:0] RESET_BLANK = {tcce_pkg::ATTR_RESET,
                                                           tcce_pkg::CH_SPACE};

    // Sequencer and cursor state
    tcce_pkg::state_t state_reg, state_next;
    logic [tcce_pkg::CHAR_W-1:0] code_reg, code_next;
    logic [tcce_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic [CIW-1:0]              col_reg, col_next;
    logic [RW-1:0]               row_reg, row_next;
    logic [AW-1:0]               pos_reg, pos_next;
    logic [AW-1:0]               cnt_reg, cnt_next;
    logic [tcce_pkg::ATTR_W-1:0] attr_reg, attr_next;
    logic [tcce_pkg::CELL_W-1:0] value_reg, value_next;
    logic                        scrolled_reg, scrolled_next;

    // Result register
    logic                            out_valid_reg, out_valid_next;
    logic [tcce_pkg::COL_OUT_W-1:0]  out_col_reg, out_col_next;
    logic [tcce_pkg::LINE_OUT_W-1:0] out_line_reg, out_line_next;
    logic [tcce_pkg::LOC_W-1:0]      out_loc_reg, out_loc_next;
    logic [tcce_pkg::CELL_W-1:0]     out_value_reg, out_value_next;
    logic                            out_scrolled_reg, out_scrolled_next;

    // RAM port
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [tcce_pkg::CELL_W-1:0] ram_wdata;
    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [tcce_pkg::CELL_W-1:0] ram_rdata;

    // Working values
    logic [AW-1:0]               loc;
    logic [CW-1:0]               col_w;
    logic [RW:0]                 row_w;
    logic [IXW-1:0]              idx_ext;
    logic                        idx_in_range;
    logic [tcce_pkg::CELL_W-1:0] blank_cur;

    tcce_ram #(
        .WIDTH (tcce_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Linear cursor position, shared by the put address and the reported location
    assign loc          = AW'(row_reg * COLUMNS) + AW'(col_reg);
    assign idx_ext      = IXW'(idx_reg);
    assign idx_in_range = (idx_ext < IXW'(CELLS));
    assign blank_cur    = {attr_reg, tcce_pkg::CH_SPACE};

    assign in_ch.ready        = (state_reg == tcce_pkg::S_IDLE);
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.cursor_col  = out_col_reg;
    assign out_ch.cursor_line = out_line_reg;
    assign out_ch.cursor_addr = out_loc_reg;
    assign out_ch.cell_value  = out_value_reg;
    assign out_ch.scrolled    = out_scrolled_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcce_pkg::S_INIT;
            col_reg       <= '0;
            row_reg       <= '0;
            cnt_reg       <= '0;
            attr_reg      <= tcce_pkg::ATTR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            cnt_reg       <= cnt_next;
            attr_reg      <= attr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg         <= code_next;
        idx_reg          <= idx_next;
        pos_reg          <= pos_next;
        value_reg        <= value_next;
        scrolled_reg     <= scrolled_next;
        out_col_reg      <= out_col_next;
        out_line_reg     <= out_line_next;
        out_loc_reg      <= out_loc_next;
        out_value_reg    <= out_value_next;
        out_scrolled_reg <= out_scrolled_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        code_next         = code_reg;
        idx_next          = idx_reg;
        col_next          = col_reg;
        row_next          = row_reg;
        pos_next          = pos_reg;
        cnt_next          = cnt_reg;
        value_next        = value_reg;
        scrolled_next     = scrolled_reg;
        out_col_next      = out_col_reg;
        out_line_next     = out_line_reg;
        out_loc_next      = out_loc_reg;
        out_value_next    = out_value_reg;
        out_scrolled_next = out_scrolled_reg;
        ram_we            = 1'b0;
        ram_waddr         = cnt_reg;
        ram_wdata         = blank_cur;
        ram_re            = 1'b0;
        ram_raddr         = '0;
        col_w             = CW'(col_reg);
        row_w             = (RW + 1)'(row_reg);

        // Configuration takes effect at once; it is to be written only while idle, which the block does not enforce.
        attr_next = cfg_write_en ? cfg_write_data : attr_reg;

        // Drop the result once the sink has taken it.
        out_valid_next = out_valid_reg && !out_ch.ready;

        unique case (state_reg)
            tcce_pkg::S_INIT:
            begin
                // Power-up sweep: blanks carry the reset attribute.
                ram_we    = 1'b1;
                ram_wdata = RESET_BLANK;
                if (cnt_reg == LAST_CELL)
                begin
                    cnt_next   = '0;
                    state_next = tcce_pkg::S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end

            tcce_pkg::S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    code_next     = in_ch.char_code;
                    idx_next      = in_ch.cell_index;
                    value_next    = '0;
                    scrolled_next = 1'b0;
                    unique case (in_ch.operation)
                        tcce_pkg::OP_PUT:   state_next = tcce_pkg::S_POS;
                        tcce_pkg::OP_CLEAR:
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            cnt_next   = '0;
                            state_next = tcce_pkg::S_FILL;
                        end
                        tcce_pkg::OP_READ:  state_next = tcce_pkg::S_READ;
                        default:            state_next = tcce_pkg::S_DONE;
                    endcase
                end
            end

            tcce_pkg::S_POS:
            begin
                pos_next   = loc;
                state_next = tcce_pkg::S_PUT;
            end

            tcce_pkg::S_PUT:
            begin
                case (code_reg)
                    tcce_pkg::CH_BS:
                    begin
                        // Keep the prompt: never erase the first two columns.
                        if (int'(col_reg) > tcce_pkg::PROMPT_COL)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = pos_reg - AW'(1);
                            ram_wdata = blank_cur;
                            col_w     = col_w - CW'(1);
                        end
                    end
                    tcce_pkg::CH_TAB:
                    begin
                        col_w = (col_w + CW'(tcce_pkg::TAB_STOP)) & CW'(tcce_pkg::TAB_MASK);
                    end
                    tcce_pkg::CH_CR:
                    begin
                        col_w = '0;
                    end
                    tcce_pkg::CH_LF:
                    begin
                        col_w = '0;
                        row_w = row_w + (RW + 1)'(1);
                    end
                    default:
                    begin
                        if (code_reg >= tcce_pkg::CH_SPACE)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = pos_reg;
                            ram_wdata = {attr_reg, code_reg};
                            col_w     = col_w + CW'(1);
                        end
                    end
                endcase

                // Wrap at the right edge
                if (int'(col_w) >= COLUMNS)
                begin
                    col_w = '0;
                    row_w = row_w + (RW + 1)'(1);
                end
                col_next = CIW'(col_w);

                // Past the bottom: shift the screen up one row
                if (int'(row_w) >= ROWS)
                begin
                    row_next      = LAST_ROW;
                    scrolled_next = 1'b1;
                    cnt_next      = '0;
                    state_next    = tcce_pkg::S_SCROLL;
                end
                else
                begin
                    row_next   = RW'(row_w);
                    state_next = tcce_pkg::S_DONE;
                end
            end

            tcce_pkg::S_SCROLL:
            begin
                // Read one row below while writing the cell read last cycle.
                if (cnt_reg != SCROLL_END)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = cnt_reg + AW'(COLUMNS);
                end
                if (cnt_reg != '0)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cnt_reg - AW'(1);
                    ram_wdata = ram_rdata;
                end
                if (cnt_reg == SCROLL_END)
                begin
                    state_next = tcce_pkg::S_FILL;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end

            tcce_pkg::S_FILL:
            begin
                ram_we    = 1'b1;
                ram_wdata = blank_cur;
                if (cnt_reg == LAST_CELL)
                begin
                    cnt_next   = '0;
                    state_next = tcce_pkg::S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end

            tcce_pkg::S_READ:
            begin
                ram_re     = idx_in_range;
                ram_raddr  = idx_ext[AW-1:0];
                state_next = tcce_pkg::S_RDATA;
            end

            tcce_pkg::S_RDATA:
            begin
                value_next = idx_in_range ? ram_rdata : '0;
                state_next = tcce_pkg::S_DONE;
            end

            tcce_pkg::S_DONE:
            begin
                // Hold here until the result register is free.
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next    = 1'b1;
                    out_col_next      = tcce_pkg::COL_OUT_W'(col_reg);
                    out_line_next     = tcce_pkg::LINE_OUT_W'(row_reg);
                    out_loc_next      = tcce_pkg::LOC_W'(loc);
                    out_value_next    = value_reg;
                    out_scrolled_next = scrolled_reg;
                    state_next        = tcce_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = tcce_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // The cell store is never written while the engine waits for a beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tcce_pkg::S_IDLE) |-> !ram_we)
        else $error("cell store written while idle");

    // The cursor stays on the screen between items.
    assert property (@(posedge clk) disable iff (!rst_n)
        (int'(row_reg) < ROWS) && (int'(col_reg) < COLUMNS))
        else $error("cursor off screen");

    // Leaving the result state always presents a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tcce_pkg::S_DONE) && (!out_valid_reg || out_ch.ready)
        |=> out_valid_reg && (state_reg == tcce_pkg::S_IDLE))
        else $error("result not loaded");

    // Every store read stays inside the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (int'(ram_raddr) < CELLS))
        else $error("read address out of range");
`endif

endmodule

`default_nettype wire

[hdl/tcce_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tcce_ram #(
    parameter int WIDTH = tcce_pkg::CELL_W,
    parameter int DEPTH = tcce_pkg::CELLS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
